// File: hdl/joint_move_interpolator_top_defines.svh
// Assertion macros for the checker of the joint move interpolator.
`ifndef JOINT_MOVE_INTERPOLATOR_TOP_DEFINES_SVH
`define JOINT_MOVE_INTERPOLATOR_TOP_DEFINES_SVH

// Checked while out of reset.
`define JMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define JMI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/jmi_pkg.sv
package jmi_pkg;

  localparam int unsigned AXES   = 7;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 32;
  // Segment time bound: 65535 * 2^16 / 1638 < 2^22.
  localparam int unsigned TSEG_W = 22;
  // Remainder of a division by at most 15 points.
  localparam int unsigned REM_W  = 4;
  localparam int unsigned CNT_W  = 4;

  localparam int unsigned IN_DATA_W  = AXES * POS_W;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = AXES * POS_W + TIME_W;

  // Velocity limits in 1/4096 position units per second.
  localparam int unsigned VEL_FAST [AXES] = '{10240, 8192, 8192, 15974, 17613, 23552, 8192};
  localparam int unsigned VEL_SLOW [AXES] = '{2048, 1638, 1638, 3277, 3277, 4096, 1638};

  typedef struct packed {
    logic vld;
    logic origin;
  } ctl_t;

  typedef struct packed {
    logic                    origin;
    logic [TSEG_W-1:0]       step;
  } job_t;

  // Per-axis move setup: |delta| / points split into quotient and remainder.
  typedef struct packed {
    logic signed [POS_W-1:0] start;
    logic                    neg;
    logic [POS_W-1:0]        aq;
    logic [REM_W-1:0]        ar;
  } lane_job_t;

endpackage

// File: hdl/jmi_lane.sv
module jmi_lane #(
  parameter int unsigned LANE   = 0,
  parameter int unsigned POINTS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 accept_i,
  input  logic                                 origin_i,
  input  logic                                 fast_i,
  input  logic signed [jmi_pkg::POS_W-1:0]     target_i,
  output logic [jmi_pkg::TSEG_W-1:0]           tseg_o,
  output jmi_pkg::lane_job_t                   job_o
);

  localparam int unsigned LF    = jmi_pkg::VEL_FAST[LANE];
  localparam int unsigned LS    = jmi_pkg::VEL_SLOW[LANE];
  localparam int unsigned LF_SH = $clog2(LF);
  localparam int unsigned LS_SH = $clog2(LS);
  localparam int unsigned PQ_SH = $clog2(POINTS);
  // floor(ad * 2^16 / L) == (ad * ceil(2^(32+l) / L)) >> (16 + l)
  localparam logic [32:0] MF = 33'(((64'd1 << (32 + LF_SH)) + 64'(LF) - 64'd1) / 64'(LF));
  localparam logic [32:0] MS = 33'(((64'd1 << (32 + LS_SH)) + 64'(LS) - 64'd1) / 64'(LS));
  localparam logic [16:0] MQ =
    17'(((64'd1 << (16 + PQ_SH)) + 64'(POINTS) - 64'd1) / 64'(POINTS));

  logic signed [jmi_pkg::POS_W-1:0] pos_q;

  logic [16:0]                      delta;
  logic [16:0]                      mag;

  logic [jmi_pkg::POS_W-1:0]        s1_ad_q;
  logic                             s1_neg_q;
  logic                             s1_fast_q;
  logic signed [jmi_pkg::POS_W-1:0] s1_start_q;

  logic [48:0]                      s2_pt_q;
  logic [32:0]                      s2_pq_q;
  logic [jmi_pkg::POS_W-1:0]        s2_ad_q;
  logic                             s2_neg_q;
  logic                             s2_fast_q;
  logic signed [jmi_pkg::POS_W-1:0] s2_start_q;

  logic [jmi_pkg::TSEG_W-1:0]       t_d;
  logic [jmi_pkg::POS_W-1:0]        aq_d;
  logic [jmi_pkg::POS_W-1:0]        aqp;
  logic [jmi_pkg::REM_W-1:0]        ar_d;

  logic [jmi_pkg::TSEG_W-1:0]       s3_t_q;
  jmi_pkg::lane_job_t               s3_job_q;
  jmi_pkg::lane_job_t               s4_job_q;
  jmi_pkg::lane_job_t               s5_job_q;

  assign delta = {target_i[jmi_pkg::POS_W-1], target_i} - {pos_q[jmi_pkg::POS_W-1], pos_q};
  assign mag   = delta[16] ? (~delta + 17'd1) : delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept_i) begin
      pos_q <= target_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (origin_i) begin
        s1_ad_q    <= '0;
        s1_neg_q   <= 1'b0;
        s1_start_q <= target_i;
      end else begin
        s1_ad_q    <= mag[jmi_pkg::POS_W-1:0];
        s1_neg_q   <= delta[16];
        s1_start_q <= pos_q;
      end
      s1_fast_q <= fast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_pt_q    <= {33'd0, s1_ad_q} * {16'd0, (s1_fast_q ? MF : MS)};
      s2_pq_q    <= {17'd0, s1_ad_q} * {16'd0, MQ};
      s2_ad_q    <= s1_ad_q;
      s2_neg_q   <= s1_neg_q;
      s2_fast_q  <= s1_fast_q;
      s2_start_q <= s1_start_q;
    end
  end

  always_comb begin
    if (s2_fast_q) begin
      t_d = jmi_pkg::TSEG_W'(s2_pt_q >> (16 + LF_SH));
    end else begin
      t_d = jmi_pkg::TSEG_W'(s2_pt_q >> (16 + LS_SH));
    end
    aq_d = jmi_pkg::POS_W'(s2_pq_q >> (16 + PQ_SH));
    aqp  = jmi_pkg::POS_W'(aq_d * jmi_pkg::POS_W'(POINTS));
    ar_d = jmi_pkg::REM_W'(s2_ad_q - aqp);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_t_q         <= t_d;
      s3_job_q.start <= s2_start_q;
      s3_job_q.neg   <= s2_neg_q;
      s3_job_q.aq    <= aq_d;
      s3_job_q.ar    <= ar_d;
      // Wait out the max and step-time stages of the merge.
      s4_job_q       <= s3_job_q;
      s5_job_q       <= s4_job_q;
    end
  end

  assign tseg_o = s3_t_q;
  assign job_o  = s5_job_q;

endmodule

// File: hdl/jmi_merge.sv
module jmi_merge #(
  parameter int unsigned JOINTS = 7,
  parameter int unsigned POINTS = 10
) (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic [jmi_pkg::TSEG_W-1:0]        tseg_i [JOINTS],
  output logic [jmi_pkg::TSEG_W-1:0]        step_o
);

  localparam int unsigned LT = $clog2(POINTS);
  localparam logic [jmi_pkg::TSEG_W:0] MT = (jmi_pkg::TSEG_W + 1)'(
    ((64'd1 << (jmi_pkg::TSEG_W + LT)) + 64'(POINTS) - 64'd1) / 64'(POINTS));
  localparam int unsigned PW = 2 * jmi_pkg::TSEG_W + 1;

  logic [jmi_pkg::TSEG_W-1:0] tmax_d;
  logic [jmi_pkg::TSEG_W-1:0] tmax_q;
  logic [PW-1:0]              prod_q;

  always_comb begin
    tmax_d = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (tseg_i[j] > tmax_d) begin
        tmax_d = tseg_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tmax_q <= tmax_d;
      prod_q <= {{(jmi_pkg::TSEG_W + 1){1'b0}}, tmax_q} * {{jmi_pkg::TSEG_W{1'b0}}, MT};
    end
  end

  // Slowest axis time divided by the point count.
  assign step_o = jmi_pkg::TSEG_W'(prod_q >> (jmi_pkg::TSEG_W + LT));

endmodule

// File: hdl/jmi_emit.sv
module jmi_emit #(
  parameter int unsigned POINTS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  input  jmi_pkg::job_t                     job_i,
  input  jmi_pkg::lane_job_t                lane_i [jmi_pkg::AXES],
  output logic                              job_take_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [jmi_pkg::POS_W-1:0]  out_pos_o [jmi_pkg::AXES],
  output logic [jmi_pkg::TIME_W-1:0]        out_time_o,
  output logic                              out_last_o
);

  logic                             busy_q, busy_d;
  logic [jmi_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                             origin_q;
  logic [jmi_pkg::TSEG_W-1:0]       step_q;
  jmi_pkg::lane_job_t               lane_q [jmi_pkg::AXES];
  logic [jmi_pkg::POS_W-1:0]        acc_q [jmi_pkg::AXES];
  logic [jmi_pkg::POS_W-1:0]        acc_d [jmi_pkg::AXES];
  logic [jmi_pkg::REM_W-1:0]        rem_q [jmi_pkg::AXES];
  logic [jmi_pkg::REM_W-1:0]        rem_d [jmi_pkg::AXES];
  logic [jmi_pkg::TIME_W-1:0]       time_q, time_d;

  logic                             out_valid_q;
  logic signed [jmi_pkg::POS_W-1:0] out_pos_q [jmi_pkg::AXES];
  logic signed [jmi_pkg::POS_W-1:0] pos_d [jmi_pkg::AXES];
  logic [jmi_pkg::TIME_W-1:0]       out_time_q;
  logic                             out_last_q;

  logic                             load;
  logic                             take;
  logic                             last_now;
  logic [jmi_pkg::CNT_W-1:0]        cnt_next;
  logic [jmi_pkg::CNT_W-1:0]        npts;
  logic [jmi_pkg::TIME_W:0]         tsum;
  logic [jmi_pkg::TIME_W-1:0]       new_time;
  logic [jmi_pkg::REM_W:0]          rsum;
  logic [jmi_pkg::POS_W-1:0]        qsum;
  logic signed [jmi_pkg::POS_W+1:0] qoff;
  logic signed [jmi_pkg::POS_W+1:0] psum;

  assign cnt_next = cnt_q + jmi_pkg::CNT_W'(1);
  assign npts     = origin_q ? jmi_pkg::CNT_W'(1) : jmi_pkg::CNT_W'(POINTS);
  assign last_now = (cnt_next == npts);
  assign load     = busy_q && (!out_valid_q || out_ready_i);
  // A new job starts in the cycle the previous job's last point loads.
  assign take     = job_valid_i && (!busy_q || (load && last_now));
  assign tsum     = {1'b0, time_q} + jmi_pkg::TIME_W'(step_q);
  assign new_time = tsum[jmi_pkg::TIME_W] ? '1 : tsum[jmi_pkg::TIME_W-1:0];

  // Point i per axis: q_i = floor(i * |delta| / points), kept as quotient and remainder.
  always_comb begin
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      rsum = {1'b0, rem_q[j]} + {1'b0, lane_q[j].ar};
      qsum = acc_q[j] + lane_q[j].aq;
      if (rsum >= (jmi_pkg::REM_W + 1)'(POINTS)) begin
        rsum = rsum - (jmi_pkg::REM_W + 1)'(POINTS);
        qsum = qsum + jmi_pkg::POS_W'(1);
      end
      acc_d[j] = qsum;
      rem_d[j] = rsum[jmi_pkg::REM_W-1:0];
      qoff     = lane_q[j].neg ? -$signed({2'b00, qsum}) : $signed({2'b00, qsum});
      psum     = {{2{lane_q[j].start[jmi_pkg::POS_W-1]}}, lane_q[j].start} + qoff;
      pos_d[j] = psum[jmi_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    time_d = time_q;
    if (load) begin
      cnt_d  = cnt_next;
      time_d = new_time;
      if (last_now) begin
        busy_d = 1'b0;
      end
    end
    if (take) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      if (job_i.origin) begin
        time_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      time_q <= time_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        out_pos_q[j] <= pos_d[j];
      end
      out_time_q <= new_time;
      out_last_q <= last_now;
    end
    // A taken job restarts the accumulators.
    if (load || take) begin
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        acc_q[j] <= take ? '0 : acc_d[j];
        rem_q[j] <= take ? '0 : rem_d[j];
      end
    end
    if (take) begin
      origin_q <= job_i.origin;
      step_q   <= job_i.step;
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        lane_q[j] <= lane_i[j];
      end
    end
  end

  assign job_take_o  = take;
  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_time_o  = out_time_q;
  assign out_last_o  = out_last_q;

endmodule

// File: hdl/joint_move_interpolator_top.sv
// Channel   Group   Payload (low bit first)
// input     s_axis  tdata: target_0..target_6 (16b each); tuser: req_type, fast_mode
// output    m_axis  tdata: point_pos_0..point_pos_6 (16b each), point_time (32b);
//                   tlast: last_point
//
// A move item gives POINTS_PER_MOVE points, one per cycle while m_axis is ready; an origin item gives one.
// The point emitter sets the sustained rate; it takes the next job as the last point of the previous one loads.
// The first point leaves after the lane setup multiplies, the max tree and step-time multiply of the merge,
// and the emitter's output register. Reset clears the axis positions, time and all valids.
// A stalled m_axis holds the emitter; the setup pipeline then holds and s_axis_tready drops.
module joint_move_interpolator_top #(
  parameter int unsigned JOINT_COUNT     = 7,
  parameter int unsigned POINTS_PER_MOVE = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // target_0 .. target_6
  input  logic [jmi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type, fast_mode
  input  logic [jmi_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // point_pos_0 .. point_pos_6, point_time
  output logic [jmi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // last_point
  output logic                               m_axis_tlast
);

  localparam int unsigned DEPTH = 5;

  logic                             adv;
  logic                             accept;
  logic                             job_take;
  jmi_pkg::ctl_t                    ctl_q [DEPTH];
  jmi_pkg::job_t                    job;
  logic [jmi_pkg::TSEG_W-1:0]       job_step;
  logic [jmi_pkg::TSEG_W-1:0]       tseg [JOINT_COUNT];
  jmi_pkg::lane_job_t               lane_job [jmi_pkg::AXES];
  logic signed [jmi_pkg::POS_W-1:0] out_pos [jmi_pkg::AXES];
  logic [jmi_pkg::TIME_W-1:0]       out_time;

  // Whole setup pipeline moves together; it holds only when a finished job waits.
  assign adv           = !ctl_q[DEPTH-1].vld || job_take;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (adv) begin
      ctl_q[0].vld    <= accept;
      ctl_q[0].origin <= !s_axis_tuser[0];
      for (int k = 1; k < DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  for (genvar j = 0; j < jmi_pkg::AXES; j++) begin : g_lane
    if (j < JOINT_COUNT) begin : g_on
      jmi_lane #(
        .LANE   (j),
        .POINTS (POINTS_PER_MOVE)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .adv_i    (adv),
        .accept_i (accept),
        .origin_i (!s_axis_tuser[0]),
        .fast_i   (s_axis_tuser[1]),
        .target_i (s_axis_tdata[j*jmi_pkg::POS_W +: jmi_pkg::POS_W]),
        .tseg_o   (tseg[j]),
        .job_o    (lane_job[j])
      );
    end else begin : g_off
      assign lane_job[j] = '0;
    end
  end

  jmi_merge #(
    .JOINTS (JOINT_COUNT),
    .POINTS (POINTS_PER_MOVE)
  ) u_merge (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .tseg_i (tseg),
    .step_o (job_step)
  );

  assign job = '{origin: ctl_q[DEPTH-1].origin, step: job_step};

  jmi_emit #(
    .POINTS (POINTS_PER_MOVE)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (ctl_q[DEPTH-1].vld),
    .job_i       (job),
    .lane_i      (lane_job),
    .job_take_o  (job_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_time_o  (out_time),
    .out_last_o  (m_axis_tlast)
  );

  for (genvar j = 0; j < jmi_pkg::AXES; j++) begin : g_pack
    assign m_axis_tdata[j*jmi_pkg::POS_W +: jmi_pkg::POS_W] = out_pos[j];
  end
  assign m_axis_tdata[jmi_pkg::AXES*jmi_pkg::POS_W +: jmi_pkg::TIME_W] = out_time;

endmodule

// File: hdl/jmi_chk.sv
`include "joint_move_interpolator_top_defines.svh"

module jmi_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [jmi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  logic                        out_take;
  logic [jmi_pkg::TIME_W-1:0]  pt_time;

  assign out_take = m_axis_tvalid && m_axis_tready;
  assign pt_time  = m_axis_tdata[jmi_pkg::AXES*jmi_pkg::POS_W +: jmi_pkg::TIME_W];

  // Output item waits until taken.
  `JMI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "m_axis item dropped")

  // Reset leaves the output empty.
  `JMI_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "m_axis valid after reset")

  // Points of one move leave without gaps.
  `JMI_ASSERT(a_no_gap, out_take && !m_axis_tlast |=> m_axis_tvalid, "gap inside a move")

  // Time never goes back within a move.
  `JMI_ASSERT(a_time_up, out_take && !m_axis_tlast |=> pt_time >= $past(pt_time), "time decreased")

endmodule

bind joint_move_interpolator_top jmi_chk u_jmi_chk (.*);

// File: sim/joint_move_interpolator_top_tb.sv
`timescale 1ns / 100ps

module joint_move_interpolator_top_tb;

  localparam int unsigned NUM_JOINTS  = 7;
  localparam int          MOVE_POINTS = 10;

  localparam logic REQ_ORIGIN = 1'b0;
  localparam logic REQ_MOVE   = 1'b1;

  localparam logic SPEED_SLOW = 1'b0;
  localparam logic SPEED_FAST = 1'b1;

  // Axis speed limits, 1/4096 position units per second.
  localparam longint FAST_LIMIT [jmi_pkg::AXES] = '{10240, 8192, 8192, 15974, 17613, 23552, 8192};
  localparam longint SLOW_LIMIT [jmi_pkg::AXES] = '{2048, 1638, 1638, 3277, 3277, 4096, 1638};

  localparam int RAND_ITEMS  = 225;
  localparam int HOLD_CYCLES = 400;

  typedef logic [jmi_pkg::AXES-1:0][jmi_pkg::POS_W-1:0] tgt_vec_t;

  typedef struct packed {
    logic     fast;
    logic     req_type;
    tgt_vec_t tgt;
  } move_req_t;

  typedef struct packed {
    tgt_vec_t                   pos;
    logic [jmi_pkg::TIME_W-1:0] ptime;
    logic                       last;
  } traj_point_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [jmi_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [jmi_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [jmi_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  joint_move_interpolator_top #(
    .JOINT_COUNT    (NUM_JOINTS),
    .POINTS_PER_MOVE(MOVE_POINTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  move_req_t   req_q [$];
  traj_point_t point_q [$];

  // Predicted block state.
  tgt_vec_t                   axis_pos = '0;
  logic [jmi_pkg::TIME_W-1:0] traj_time = '0;

  tgt_vec_t                   last_tgt = '0;

  move_req_t   tx_item;
  int unsigned tx_gap_left = 0;
  int unsigned tx_quiet_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_quiet_left = 0;
  logic        rx_hold = 1'b0;
  int          items_total = 0;
  int          items_taken = 0;
  int          points_seen = 0;
  int          mismatches = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic predict_item(input move_req_t it);
    int          st [jmi_pkg::AXES];
    int          dl [jmi_pkg::AXES];
    int          tv;
    longint      mag;
    longint      lim;
    longint      t_ax;
    longint      t_max;
    longint      step;
    longint      nt;
    traj_point_t pt;
    if (it.req_type == REQ_ORIGIN) begin
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        axis_pos[j] = (j < NUM_JOINTS) ? it.tgt[j] : '0;
      end
      traj_time = '0;
      pt.pos   = axis_pos;
      pt.ptime = '0;
      pt.last  = 1'b1;
      point_q = {point_q, pt};
    end else begin
      t_max = 0;
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        st[j] = int'($signed(axis_pos[j]));
        dl[j] = 0;
        if (j < NUM_JOINTS) begin
          tv    = int'($signed(it.tgt[j]));
          dl[j] = tv - st[j];
          mag   = longint'((dl[j] < 0) ? -dl[j] : dl[j]);
          lim   = (it.fast == SPEED_FAST) ? FAST_LIMIT[j] : SLOW_LIMIT[j];
          t_ax  = (mag <<< 16) / lim;
          if (t_ax > t_max) begin
            t_max = t_ax;
          end
        end
      end
      step = t_max / longint'(MOVE_POINTS);
      for (int i = 1; i <= MOVE_POINTS; i++) begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
          // int division truncates toward zero
          axis_pos[j] = jmi_pkg::POS_W'(st[j] + (i * dl[j]) / MOVE_POINTS);
        end
        nt = longint'(traj_time) + step;
        traj_time = (nt > 64'hFFFF_FFFF) ? '1 : nt[jmi_pkg::TIME_W-1:0];
        pt.pos   = axis_pos;
        pt.ptime = traj_time;
        pt.last  = (i == MOVE_POINTS);
        point_q = {point_q, pt};
      end
    end
  endtask

  // Mostly no gap, else short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned next_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tgt_vec_t rand_tgt();
    tgt_vec_t t;
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      t[j] = jmi_pkg::POS_W'($urandom);
    end
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input longint got_v, input longint want_v);
    $display("ERROR %0t ns point %0d: %s got 0x%0h want 0x%0h",
             $time, points_seen, what, got_v, want_v);
    mismatches++;
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_item(tx_item);
        items_taken++;
      end
      if (tx_gap_left != 0) begin
        tx_gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        tx_item = req_q.pop_front();
        s_axis_tdata  <= tx_item.tgt;
        s_axis_tuser  <= {tx_item.fast, tx_item.req_type};
        s_axis_tvalid <= 1'b1;
        tx_gap_left = next_gap(tx_quiet_left);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall_left = next_gap(rx_quiet_left);
    end
  end

  // Long back-pressure while the sender keeps offering items.
  initial begin
    wait (items_taken >= 60);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Result checker
  always @(posedge clk_i) begin : point_check
    traj_point_t got;
    traj_point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pos   = m_axis_tdata[jmi_pkg::AXES*jmi_pkg::POS_W-1:0];
      got.ptime = m_axis_tdata[jmi_pkg::OUT_DATA_W-1 -: jmi_pkg::TIME_W];
      got.last  = m_axis_tlast;
      if (point_q.size() == 0) begin
        flag_mismatch("unexpected point, time", longint'(got.ptime), longint'(0));
      end else begin
        want = point_q.pop_front();
        for (int j = 0; j < jmi_pkg::AXES; j++) begin
          if (got.pos[j] !== want.pos[j]) begin
            flag_mismatch($sformatf("point_pos_%0d", j), longint'(got.pos[j]),
                          longint'(want.pos[j]));
          end
        end
        if (got.ptime !== want.ptime) begin
          flag_mismatch("point_time", longint'(got.ptime), longint'(want.ptime));
        end
        if (got.last !== want.last) begin
          flag_mismatch("last_point", longint'(got.last), longint'(want.last));
        end
      end
      points_seen++;
    end
  end

  function automatic move_req_t mk_req(logic req_type, logic fast, int v);
    move_req_t it;
    it.req_type = req_type;
    it.fast     = fast;
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      it.tgt[j] = v[jmi_pkg::POS_W-1:0];
    end
    return it;
  endfunction

  // Both item kinds leave the axes at the target.
  task automatic queue_item(input move_req_t it);
    req_q = {req_q, it};
    last_tgt = it.tgt;
  endtask

  initial begin
    move_req_t   it;
    int          v;
    int unsigned kind;
    int          offs [jmi_pkg::AXES];
    offs = '{7, -13, 1, -1, 9, -19, 3};

    // Directed: range extremes, both speeds, zero-length moves
    queue_item(mk_req(REQ_MOVE, SPEED_FAST, 0));
    queue_item(mk_req(REQ_ORIGIN, SPEED_SLOW, 0));
    queue_item(mk_req(REQ_MOVE, SPEED_FAST, 32767));
    queue_item(mk_req(REQ_MOVE, SPEED_SLOW, -32768));
    queue_item(mk_req(REQ_MOVE, SPEED_SLOW, 32767));
    queue_item(mk_req(REQ_MOVE, SPEED_FAST, 32767));
    queue_item(mk_req(REQ_ORIGIN, SPEED_FAST, -32768));
    // one axis moves at a time, so each limit sets the segment time once
    for (int k = 0; k < jmi_pkg::AXES; k++) begin
      it = mk_req(REQ_MOVE, k[0], -32768);
      for (int j = 0; j <= k; j++) begin
        it.tgt[j] = 16'sd20000;
      end
      queue_item(it);
    end
    it = mk_req(REQ_ORIGIN, SPEED_SLOW, 0);
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      v = j * 1000 - 3000;
      it.tgt[j] = v[jmi_pkg::POS_W-1:0];
    end
    queue_item(it);
    // tiny deltas, odd then even: truncation toward zero on both signs
    for (int s = 0; s < 2; s++) begin
      it = mk_req(REQ_MOVE, s[0], 0);
      for (int j = 0; j < jmi_pkg::AXES; j++) begin
        v = int'($signed(last_tgt[j])) + (s == 0 ? offs[j] : -2 * offs[j]);
        it.tgt[j] = v[jmi_pkg::POS_W-1:0];
      end
      queue_item(it);
    end
    it = mk_req(REQ_ORIGIN, SPEED_FAST, 0);
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      it.tgt[j] = j[0] ? 16'h5555 : 16'hAAAA;
    end
    queue_item(it);
    it = mk_req(REQ_MOVE, SPEED_SLOW, 0);
    for (int j = 0; j < jmi_pkg::AXES; j++) begin
      it.tgt[j] = j[0] ? 16'hAAAA : 16'h5555;
    end
    queue_item(it);

    // Random: mostly moves, some origins
    for (int n = 0; n < RAND_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      it.fast = 1'($urandom_range(0, 1));
      it.req_type = REQ_MOVE;
      it.tgt = rand_tgt();
      if (kind < 15) begin
        it.req_type = REQ_ORIGIN;
      end else if (kind < 45) begin
        // full-range targets already set
      end else if (kind < 85) begin
        for (int j = 0; j < jmi_pkg::AXES; j++) begin
          v = int'($signed(last_tgt[j])) + int'($urandom_range(0, 600)) - 300;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          it.tgt[j] = v[jmi_pkg::POS_W-1:0];
        end
      end else if (kind < 93) begin
        it.tgt = last_tgt;
      end else begin
        v = $urandom;
        kind = $urandom_range(0, jmi_pkg::AXES - 1);
        it.tgt = last_tgt;
        it.tgt[kind] = v[jmi_pkg::POS_W-1:0];
      end
      queue_item(it);
    end

    for (int n = 0; n < 16; n++) begin
      it.req_type = (n == 10) ? REQ_ORIGIN : REQ_MOVE;
      it.fast = 1'($urandom_range(0, 1));
      it.tgt = rand_tgt();
      queue_item(it);
    end
    items_total = req_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == items_total);
    wait (point_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
